### src/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg: shared types and constants for the keyed entry table
// Field layouts of the request and response words, the entry that moves
// along the cell chain, command codes and the name packing helpers.
// ----------------------------------------------------------------------------
package ket_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int NAME_LENGTH = 10;
   localparam int NAME_BYTES  = 9;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CUR_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] DEFAULT_FORMAT_RESET = 2'd3;

   localparam logic [2:0] KIND_LOOKUP   = 3'd0;
   localparam logic [2:0] KIND_PUT_FMT  = 3'd1;
   localparam logic [2:0] KIND_PUT_NAME = 3'd2;
   localparam logic [2:0] KIND_CLEAR    = 3'd3;
   localparam logic [2:0] KIND_NEXT     = 3'd4;
   localparam logic [2:0] KIND_REWIND   = 3'd5;

   typedef logic [8*NAME_BYTES-1:0] name_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [13:0] loco_address;
      logic [1:0]  format_in;
      logic [63:0] name_in_low;
      logic [7:0]  name_in_high;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [13:0] out_address;
      logic [1:0]  out_format;
      logic [63:0] out_name_low;
      logic [7:0]  out_name_high;
      logic [5:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  fmt;
      logic [13:0] addr;
      name_type    name;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } ring_ctl_type;

   // stored form of a name: the last character slot and beyond are zero
   function automatic name_type store_name(input logic [63:0] lo, input logic [7:0] hi);
      name_type n;
      n = {hi, lo};
      for (int j = 0; j < NAME_BYTES; j++) begin
         if (j >= NAME_LENGTH - 1) begin
            n[8*j +: 8] = 8'h00;
         end
      end
      return n;
   endfunction

   // shown form: everything from the first zero character on reads as zero
   function automatic name_type show_name(input name_type s);
      name_type n;
      logic     stop;
      n    = s;
      stop = 1'b0;
      for (int j = 0; j < NAME_BYTES; j++) begin
         if (n[8*j +: 8] == 8'h00 || j >= NAME_LENGTH) begin
            stop = 1'b1;
         end
         if (stop) begin
            n[8*j +: 8] = 8'h00;
         end
      end
      return n;
   endfunction

endpackage

### src/ket_cell.sv
// ----------------------------------------------------------------------------
// ket_cell: one table entry in the rotating chain
// Holds a key/format word and a name; on shift it takes its neighbor's
// entry, on clear it empties its key.
// ----------------------------------------------------------------------------
module ket_cell
   import ket_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ring_ctl_type ring_ctl,
   input  entry_type    entry_in,
   output entry_type    entry_out
);

   logic [1:0]  fmt_ff,  fmt_in;
   logic [13:0] addr_ff, addr_in;
   name_type    name_ff, name_in;

   always_comb begin
      fmt_in  = fmt_ff;
      addr_in = addr_ff;
      name_in = name_ff;
      if (ring_ctl.clear) begin
         fmt_in  = 2'd0;
         addr_in = 14'd0;
      end else if (ring_ctl.shift) begin
         fmt_in  = entry_in.fmt;
         addr_in = entry_in.addr;
         name_in = entry_in.name;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= 2'd0;
         addr_ff <= 14'd0;
      end else begin
         fmt_ff  <= fmt_in;
         addr_ff <= addr_in;
      end
   end

   // names are only meaningful once written
   always_ff @(posedge clock) begin
      name_ff <= name_in;
   end

   assign entry_out = '{fmt: fmt_ff, addr: addr_ff, name: name_ff};

endmodule

### src/ket_seq.sv
// ----------------------------------------------------------------------------
// ket_seq: command sequencer for the keyed entry table
// Rotates the cell chain one full lap per pass, inspects the entry at the
// head and feeds back the possibly modified entry; builds the response word.
// ----------------------------------------------------------------------------
module ket_seq
   import ket_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic [1:0]   default_format,
   input  entry_type    head_entry,
   output entry_type    feed_entry,
   output ring_ctl_type ring_ctl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LAP1 = 2'd1;
   localparam logic [1:0] ST_LAP2 = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff,       state_in;
   logic [2:0]       kind_ff,        kind_in;
   logic [13:0]      addr_ff,        addr_in;
   logic [1:0]       fmt_ff,         fmt_in;
   name_type         name_ff,        name_in;
   logic [IDX_W-1:0] idx_ff,         idx_in;
   logic             found_ff,       found_in;
   logic             empty_found_ff, empty_found_in;
   logic [IDX_W-1:0] empty_idx_ff,   empty_idx_in;
   logic             ok_ff,          ok_in;
   logic [13:0]      res_addr_ff,    res_addr_in;
   logic [1:0]       res_fmt_ff,     res_fmt_in;
   name_type         res_name_ff,    res_name_in;
   logic [5:0]       cnt_ff,         cnt_in;
   logic [5:0]       used_ff,        used_in;
   logic [CUR_W-1:0] cursor_ff,      cursor_in;
   logic             rsp_valid_ff,   rsp_valid_in;
   rsp_type          rsp_ff,         rsp_in;

   logic accept;
   logic is_match;
   logic head_used;
   logic lap_end;
   logic is_put;
   logic load_rsp;
   logic clear_now;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_match  = (addr_ff != 14'd0) && (head_entry.addr == addr_ff);
   assign head_used = (head_entry.addr != 14'd0);
   assign lap_end   = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign is_put    = (kind_ff == KIND_PUT_FMT) || (kind_ff == KIND_PUT_NAME);
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign clear_now = accept && (req_data.kind == KIND_CLEAR);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      addr_in        = addr_ff;
      fmt_in         = fmt_ff;
      name_in        = name_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      ok_in          = ok_ff;
      res_addr_in    = res_addr_ff;
      res_fmt_in     = res_fmt_ff;
      res_name_in    = res_name_ff;
      cnt_in         = cnt_ff;
      used_in        = used_ff;
      cursor_in      = cursor_ff;
      feed_entry     = head_entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in        = req_data.kind;
               addr_in        = req_data.loco_address;
               fmt_in         = req_data.format_in;
               name_in        = store_name(req_data.name_in_low, req_data.name_in_high);
               idx_in         = '0;
               found_in       = 1'b0;
               empty_found_in = 1'b0;
               cnt_in         = 6'd0;
               ok_in          = 1'b0;
               res_addr_in    = 14'd0;
               res_name_in    = '0;
               res_fmt_in     = (req_data.kind == KIND_LOOKUP) ? default_format : 2'd0;
               unique case (req_data.kind)
                  KIND_LOOKUP, KIND_PUT_FMT, KIND_PUT_NAME, KIND_NEXT: begin
                     state_in = ST_LAP1;
                  end
                  KIND_CLEAR: begin
                     ok_in    = 1'b1;
                     used_in  = 6'd0;
                     state_in = ST_DONE;
                  end
                  KIND_REWIND: begin
                     ok_in     = 1'b1;
                     cursor_in = '0;
                     state_in  = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_LAP1: begin
            unique case (kind_ff)
               KIND_LOOKUP: begin
                  if (is_match && !found_ff) begin
                     found_in    = 1'b1;
                     res_fmt_in  = head_entry.fmt;
                     res_name_in = show_name(head_entry.name);
                  end
               end
               KIND_PUT_FMT: begin
                  if (is_match && !found_ff) begin
                     found_in   = 1'b1;
                     feed_entry = '{fmt: fmt_ff, addr: head_entry.addr,
                                    name: head_entry.name};
                  end
               end
               KIND_PUT_NAME: begin
                  if (is_match && !found_ff) begin
                     found_in   = 1'b1;
                     feed_entry = '{fmt: head_entry.fmt, addr: head_entry.addr,
                                    name: name_ff};
                  end
               end
               KIND_NEXT: begin
                  if (!found_ff && head_used && ({1'b0, idx_ff} >= (IDX_W+1)'(cursor_ff))) begin
                     found_in    = 1'b1;
                     res_addr_in = head_entry.addr;
                     res_fmt_in  = head_entry.fmt;
                     res_name_in = show_name(head_entry.name);
                     cursor_in   = CUR_W'(idx_ff) + CUR_W'(1);
                  end
               end
               default: begin
               end
            endcase
            // remember the first free slot for a possible insert
            if (is_put && !head_used && !empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_idx_in   = idx_ff;
            end
            cnt_in = cnt_ff + {5'd0, (feed_entry.addr != 14'd0)};
            idx_in = idx_ff + IDX_W'(1);
            if (lap_end) begin
               idx_in  = '0;
               used_in = cnt_in;
               cnt_in  = 6'd0;
               ok_in   = found_in;
               if (kind_ff == KIND_NEXT && !found_in) begin
                  cursor_in = '0;
               end
               if (is_put && !found_in && addr_ff != 14'd0 && empty_found_in) begin
                  state_in = ST_LAP2;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_LAP2: begin
            if (idx_ff == empty_idx_ff) begin
               if (kind_ff == KIND_PUT_FMT) begin
                  feed_entry = '{fmt: fmt_ff, addr: addr_ff, name: '0};
               end else begin
                  feed_entry = '{fmt: default_format, addr: addr_ff, name: name_ff};
               end
            end
            cnt_in = cnt_ff + {5'd0, (feed_entry.addr != 14'd0)};
            idx_in = idx_ff + IDX_W'(1);
            if (lap_end) begin
               idx_in   = '0;
               used_in  = cnt_in;
               cnt_in   = 6'd0;
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_in.ok            = ok_ff;
         rsp_in.out_address   = res_addr_ff;
         rsp_in.out_format    = res_fmt_ff;
         rsp_in.out_name_low  = res_name_ff[63:0];
         rsp_in.out_name_high = res_name_ff[71:64];
         rsp_in.entry_count   = used_ff;
         rsp_valid_in         = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign ring_ctl.shift = (state_ff == ST_LAP1) || (state_ff == ST_LAP2);
   assign ring_ctl.clear = clear_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         used_ff      <= 6'd0;
         cnt_ff       <= 6'd0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      addr_ff        <= addr_in;
      fmt_ff         <= fmt_in;
      name_ff        <= name_in;
      found_ff       <= found_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      ok_ff          <= ok_in;
      res_addr_ff    <= res_addr_in;
      res_fmt_ff     <= res_fmt_in;
      res_name_ff    <= res_name_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/keyed_entry_table_core.sv
// ----------------------------------------------------------------------------
// keyed_entry_table_core: address-keyed table of formats and names
// Ring of entry cells with a sequencer that serves lookup, puts, clear and
// a cursor scan; one response word per request word.
// ----------------------------------------------------------------------------
// The table lives in a ring of TABLE_DEPTH cells that rotates one position
// per cycle while a command runs; the sequencer examines the entry leaving
// the ring and writes back the updated entry. Lookup, put with an existing
// key, failed puts and next-entry take one lap of TABLE_DEPTH positions,
// between accepting the request and posting the response. A put that
// inserts a new key needs a second lap to reach the first free slot.
// Clear, rewind and unknown commands finish without a lap. The next
// request word is taken while the previous response still waits.
// ----------------------------------------------------------------------------
module keyed_entry_table_core
   import ket_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [1:0] csr_write_data
);

   logic [1:0]   default_format_ff, default_format_in;
   entry_type    chain [TABLE_DEPTH];
   entry_type    feed_entry;
   ring_ctl_type ring_ctl;

   assign default_format_in = csr_write_en ? csr_write_data : default_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_format_ff <= DEFAULT_FORMAT_RESET;
      end else begin
         default_format_ff <= default_format_in;
      end
   end

   ket_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .default_format (default_format_ff),
      .head_entry     (chain[TABLE_DEPTH-1]),
      .feed_entry     (feed_entry),
      .ring_ctl       (ring_ctl)
   );

   // cell k takes from cell k-1; the sequencer closes the ring
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_first
         ket_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ring_ctl  (ring_ctl),
            .entry_in  (feed_entry),
            .entry_out (chain[k])
         );
      end else begin : g_rest
         ket_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ring_ctl  (ring_ctl),
            .entry_in  (chain[k-1]),
            .entry_out (chain[k])
         );
      end
   end

endmodule
